### design/sitoa_pkg.sv
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared types and constants for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

  localparam int VALUE_W    = 32;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int CHAR_W     = 8;

  localparam logic [CHAR_W-1:0]  CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0]  CH_ZERO  = 8'h30;
  localparam logic [DIGIT_W-1:0] RADIX_M1 = 4'd9;

  typedef logic [DIGIT_W-1:0] digit_t;

  // per-cycle command shared by every digit cell
  typedef struct packed {
    logic clear;   // zero the digit
    logic dabble;  // add-3 correction then shift one binary bit in
    logic shift;   // take the lower neighbor's digit
  } cell_ctrl_t;

endpackage

### design/sitoa_digit_cell.sv
// ----------------------------------------------------------------------------
// sitoa_digit_cell
// One bcd digit of the conversion row: clear, double-dabble step or digit shift.
// ----------------------------------------------------------------------------
module sitoa_digit_cell (
  input  logic                clk,
  input  sitoa_pkg::cell_ctrl_t ctrl,
  input  logic                carry_in,   // binary bit from lower neighbor
  input  sitoa_pkg::digit_t   digit_in,   // lower neighbor's digit
  output logic                carry_out,
  output sitoa_pkg::digit_t   digit
);

  sitoa_pkg::digit_t adj;

  // add 3 when the digit would overflow 9 after doubling
  always_comb begin
    if (digit > sitoa_pkg::DIGIT_W'(4)) begin
      adj = digit + sitoa_pkg::DIGIT_W'(3);
    end else begin
      adj = digit;
    end
  end

  assign carry_out = adj[sitoa_pkg::DIGIT_W-1];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.dabble) begin
      digit <= {adj[sitoa_pkg::DIGIT_W-2:0], carry_in};
    end else if (ctrl.shift) begin
      digit <= digit_in;
    end
  end

endmodule

### design/signed_int_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a 32-bit two's complement integer into decimal ascii characters.
// ----------------------------------------------------------------------------
// Input channel s_*: one item is one signed 32-bit value in s_tdata.
// Output channel m_*: one item per character, most significant first; a
// negative value starts with '-', zero gives a single '0', no leading zeros.
// m_tlast marks the final character of each number (1 to 11 characters).
// The magnitude runs through a row of ten bcd digit cells, one binary bit a
// cycle; leading zero digits are then shifted out of the top cell one a
// cycle, and the remaining digits leave from the top cell one a cycle while
// the receiver does not stall. s_tready is high only between items, so a new
// value is not accepted until the final character of the previous one is
// loaded. The output register holds the current character while m_tready is
// low and the row waits; the next item may be accepted while the final
// character of the previous one is still waiting.
// Reset (rst, synchronous) returns to idle and drops m_tvalid.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic signed [sitoa_pkg::VALUE_W-1:0] s_tdata,   // value
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic        [sitoa_pkg::CHAR_W-1:0]  m_tdata,   // char_code
  output logic                                 m_tlast    // last_char
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  localparam int CNT_W = $clog2(sitoa_pkg::VALUE_W);
  localparam int REM_W = $clog2(sitoa_pkg::NUM_DIGITS + 1);

  logic [2:0]                    state;
  logic [CNT_W-1:0]              cnt;
  logic [REM_W-1:0]              remain;
  logic                          neg;
  logic [sitoa_pkg::VALUE_W-1:0] mag;

  sitoa_pkg::cell_ctrl_t ctrl;
  sitoa_pkg::digit_t     digit [sitoa_pkg::NUM_DIGITS];
  logic                  carry [sitoa_pkg::NUM_DIGITS+1];
  sitoa_pkg::digit_t     top_digit;

  logic accept;
  logic out_free;
  logic skip_zero;
  logic emit_step;

  assign top_digit = digit[sitoa_pkg::NUM_DIGITS-1];
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign skip_zero = (state == ST_SKIP) && (top_digit == '0) && (remain > REM_W'(1));
  assign emit_step = (state == ST_EMIT) && out_free;

  assign ctrl.clear  = accept;
  assign ctrl.dabble = (state == ST_CONV);
  assign ctrl.shift  = skip_zero || emit_step;

  assign carry[0] = mag[sitoa_pkg::VALUE_W-1];

  for (genvar i = 0; i < sitoa_pkg::NUM_DIGITS; i++) begin : g_cell
    sitoa_pkg::digit_t lower;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_rest
      assign lower = digit[i-1];
    end
    sitoa_digit_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .carry_in  (carry[i]),
      .digit_in  (lower),
      .carry_out (carry[i+1]),
      .digit     (digit[i])
    );
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      remain <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_CONV;
            cnt   <= '0;
          end
        end
        ST_CONV: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(sitoa_pkg::VALUE_W - 1)) begin
            state  <= ST_SKIP;
            remain <= REM_W'(sitoa_pkg::NUM_DIGITS);
          end
        end
        ST_SKIP: begin
          if (skip_zero) begin
            remain <= remain - REM_W'(1);
          end else if (neg) begin
            state <= ST_SIGN;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            remain <= remain - REM_W'(1);
            if (remain == REM_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // magnitude shifter, formed at load
  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= s_tdata[sitoa_pkg::VALUE_W-1];
      if (s_tdata[sitoa_pkg::VALUE_W-1]) begin
        mag <= ~s_tdata + sitoa_pkg::VALUE_W'(1);
      end else begin
        mag <= s_tdata;
      end
    end else if (state == ST_CONV) begin
      mag <= {mag[sitoa_pkg::VALUE_W-2:0], 1'b0};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_SIGN) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (emit_step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_SIGN) && out_free) begin
      m_tdata <= sitoa_pkg::CH_MINUS;
      m_tlast <= 1'b0;
    end else if (emit_step) begin
      m_tdata <= sitoa_pkg::CH_ZERO | {{(sitoa_pkg::CHAR_W-sitoa_pkg::DIGIT_W){1'b0}}, top_digit};
      m_tlast <= (remain == REM_W'(1));
    end
  end

  // the ten-digit row never overflows a 32-bit magnitude
  a_no_top_carry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> !carry[sitoa_pkg::NUM_DIGITS])
    else $error("bcd row overflow");

  // emitting always has a digit left
  a_emit_remain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (remain != '0))
    else $error("emit with no digit left");

  // a character taken from the row is a decimal digit
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    emit_step |-> (top_digit <= sitoa_pkg::RADIX_M1))
    else $error("non-decimal digit in row");

  // an accepted item starts conversion with a fresh count
  a_start_conv: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_CONV) && (cnt == '0))
    else $error("conversion did not start");

endmodule

### sim/signed_int_to_decimal_ascii_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_checker
// Watches both stream channels of the converter, works out the decimal text
// for every accepted value and compares each character and its last flag.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  input  logic                                 s_tready,
  input  logic signed [sitoa_pkg::VALUE_W-1:0] s_tdata,   // value
  input  logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic        [sitoa_pkg::CHAR_W-1:0]  m_tdata,   // char_code
  input  logic                                 m_tlast,   // last_char
  output int                                   mismatch_count,
  output int                                   chars_pending
);

  localparam int RADIX = 10;

  typedef struct packed {
    logic [sitoa_pkg::CHAR_W-1:0] code;
    logic                         last;
  } text_char_t;

  text_char_t text_q[$];

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // magnitude at 33 bits so the most negative value converts exactly
  function automatic void queue_decimal_text(
    input logic signed [sitoa_pkg::VALUE_W-1:0] v
  );
    logic [sitoa_pkg::VALUE_W:0]   mag;
    logic [sitoa_pkg::DIGIT_W-1:0] digits [sitoa_pkg::NUM_DIGITS];
    int n;
    int i;
    mag = v[sitoa_pkg::VALUE_W-1] ? -{v[sitoa_pkg::VALUE_W-1], v} : {1'b0, v};
    n = 0;
    do begin
      digits[n] = sitoa_pkg::DIGIT_W'(mag % RADIX);
      mag = mag / RADIX;
      n++;
    end while (mag != 0);
    if (v[sitoa_pkg::VALUE_W-1]) text_q.push_back('{sitoa_pkg::CH_MINUS, 1'b0});
    for (i = n - 1; i >= 0; i--) begin
      text_q.push_back('{sitoa_pkg::CH_ZERO + sitoa_pkg::CHAR_W'(digits[i]), i == 0});
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      // check the output first: a value taken at this edge cannot have a char out yet
      if (m_tvalid && m_tready) begin
        if (text_q.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last %0b", m_tdata, m_tlast));
        end else begin
          want = text_q.pop_front();
          if (m_tdata !== want.code)
            report_mismatch($sformatf("char 0x%02h, wanted 0x%02h", m_tdata, want.code));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("last flag %0b on char 0x%02h, wanted %0b",
                                      m_tlast, m_tdata, want.last));
        end
      end
      if (s_tvalid && s_tready) queue_decimal_text(s_tdata);
    end
    chars_pending <= text_q.size();
  end

endmodule

### sim/tb_signed_int_to_decimal_ascii_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_core
// Drives signed values into the converter with random gaps and output stalls,
// corner values first, then random values across all digit counts; the
// checker predicts the text and counts mismatches.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii_core;

  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 60;

  logic                                 clk      = 1'b0;
  logic                                 rst      = 1'b1;
  logic                                 s_tvalid = 1'b0;
  logic                                 s_tready;
  logic signed [sitoa_pkg::VALUE_W-1:0] s_tdata  = '0;
  logic                                 m_tvalid;
  logic                                 m_tready = 1'b0;
  logic        [sitoa_pkg::CHAR_W-1:0]  m_tdata;
  logic                                 m_tlast;

  int   mismatch_count;
  int   chars_pending;
  int   send_idle = 23;
  int   recv_idle = 67;
  logic hold_req  = 1'b0;

  logic signed [sitoa_pkg::VALUE_W-1:0] corner_values [22] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
    32'sd2147483647, 32'h8000_0000, -32'sd2147483647, 32'sd1000000000,
    32'sd999999999, -32'sd999999999, 32'sd123456789, -32'sd123456789,
    32'sd1234567890, -32'sd1000000000, 32'h5555_5555, 32'hAAAA_AAAA,
    -32'sd9, 32'sd7
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  signed_int_to_decimal_ascii_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  signed_int_to_decimal_ascii_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .mismatch_count (mismatch_count),
    .chars_pending  (chars_pending)
  );

  task automatic send_value(input logic signed [sitoa_pkg::VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // mix of full-range values, values of every digit count, decade edges and fixed extremes
  task automatic send_random_values(input int count);
    longint                               lim;
    logic signed [sitoa_pkg::VALUE_W-1:0] v;
    repeat (count) begin
      case ($urandom_range(3))
        0: v = $urandom;
        1: begin
          lim = 1;
          repeat ($urandom_range(1, 9)) lim *= 10;
          v = sitoa_pkg::VALUE_W'($urandom % lim);
          if ($urandom_range(1)) v = -v;
        end
        2: begin
          lim = 1;
          repeat ($urandom_range(1, 9)) lim *= 10;
          v = sitoa_pkg::VALUE_W'(lim - $urandom_range(1));
          if ($urandom_range(1)) v = -v;
        end
        default: begin
          case ($urandom_range(4))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = '0;
            3:       v = -1;
            default: v = 32'h8000_0001;
          endcase
        end
      endcase
      send_value(v);
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    bit hold_done;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin : stimulus
    int k;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (k = 0; k < 22; k++) send_value(corner_values[k]);
    send_random_values(96);
    send_idle <= 67;
    recv_idle <= 23;
    send_random_values(96);
    send_idle <= 0;
    recv_idle <= 0;
    hold_req  <= 1'b1;
    send_random_values(96);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
